// ===== rtl/ccl_pkg.sv =====
// Shared constants and types of the console command line parser.
`default_nettype none
package ccl_pkg;

   // Default number of command word characters kept.
   localparam int WORD_MAX_DEFAULT = 8;

   // Control characters and character ranges.
   localparam logic [7:0] CHAR_CR       = 8'h0D;
   localparam logic [7:0] CHAR_LF       = 8'h0A;
   localparam logic [7:0] CHAR_SPACE    = 8'h20;
   localparam logic [7:0] CHAR_ZERO     = 8'h30;
   localparam logic [7:0] CHAR_NINE     = 8'h39;
   localparam logic [7:0] CHAR_HEX_MARK = 8'h78;
   localparam logic [7:0] CHAR_LOWER_A  = 8'h61;
   localparam logic [7:0] CHAR_LOWER_F  = 8'h66;
   localparam logic [7:0] CHAR_HEX_BASE = 8'h57;

   // Largest space count; the counter saturates there.
   localparam logic [7:0] SPACE_COUNT_MAX = 8'hFF;

   // Field numbers that carry a value.
   localparam logic [7:0] FIELD_ONE = 8'd1;
   localparam logic [7:0] FIELD_TWO = 8'd2;

   typedef logic [2:0] cmd_code_type;

   localparam cmd_code_type CMD_FW      = 3'd0;
   localparam cmd_code_type CMD_SOC     = 3'd1;
   localparam cmd_code_type CMD_PHSOC   = 3'd2;
   localparam cmd_code_type CMD_USB     = 3'd3;
   localparam cmd_code_type CMD_WR      = 3'd4;
   localparam cmd_code_type CMD_RD      = 3'd5;
   localparam cmd_code_type CMD_UNKNOWN = 3'd6;

   // Known command words, padded with zeros to the longest one.
   localparam int KNOWN_WORDS = 6;
   localparam int KNOWN_MAX   = 7;

   typedef logic [7:0] word_text_type [KNOWN_MAX];

   localparam word_text_type KNOWN_TEXT [KNOWN_WORDS] = '{
      '{8'h70, 8'h62, 8'h66, 8'h77, 8'h00, 8'h00, 8'h00},   // pbfw
      '{8'h70, 8'h62, 8'h73, 8'h6F, 8'h63, 8'h00, 8'h00},   // pbsoc
      '{8'h70, 8'h62, 8'h70, 8'h68, 8'h73, 8'h6F, 8'h63},   // pbphsoc
      '{8'h70, 8'h62, 8'h75, 8'h73, 8'h62, 8'h00, 8'h00},   // pbusb
      '{8'h70, 8'h62, 8'h77, 8'h72, 8'h00, 8'h00, 8'h00},   // pbwr
      '{8'h70, 8'h62, 8'h72, 8'h64, 8'h00, 8'h00, 8'h00}    // pbrd
   };

   localparam int KNOWN_LEN [KNOWN_WORDS] = '{4, 5, 7, 5, 4, 4};

   // Control of one argument field accumulator.
   typedef struct packed {
      logic step;    // take the current character into the field
      logic clear;   // end of line: back to zero, decimal mode
   } field_ctl_type;

endpackage : ccl_pkg
`default_nettype wire

// ===== rtl/console_command_line_parser_unit.sv =====
// Top level of the console command line parser: byte register, line state and result register.
//
//   Channel | Direction | Handshake            | Payload
//   --------+-----------+----------------------+----------------------------------------------
//   req     | in        | req_valid, req_ready | req_rx_byte
//   rsp     | out       | rsp_valid, rsp_ready | rsp_command_code, rsp_field_count,
//           |           |                      | rsp_first_value, rsp_second_value
//
// Each accepted byte is held in an input register and processed from there. A byte other
// than a carriage return is processed in the cycle after it is accepted, so the block takes
// one byte per cycle while no carriage return waits. The line state and, for a carriage
// return, rsp_valid are updated when the byte is processed. A carriage return produces one
// transaction on the result channel, held in a single output register.
// Reset is synchronous and active high and clears the line state and both valid flags.
// A carriage return waits in the input register only while the output register still
// holds an untaken transaction; the bytes behind it wait with it, and no other byte stalls.
`default_nettype none
module console_command_line_parser_unit #(
   parameter int WORD_MAX = ccl_pkg::WORD_MAX_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [7:0]            req_rx_byte,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output ccl_pkg::cmd_code_type      rsp_command_code,
   output logic [7:0]                 rsp_field_count,
   output logic [15:0]                rsp_first_value,
   output logic [15:0]                rsp_second_value
);
   import ccl_pkg::*;

   // The length counter saturates one above WORD_MAX, which marks a word too long to match.
   localparam int LEN_W = $clog2(WORD_MAX + 2);
   localparam int IDX_W = $clog2(WORD_MAX);

   // Input register.
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;

   // Line state.
   logic [7:0]       word_chars_ff [WORD_MAX];
   logic [LEN_W-1:0] word_length_ff, word_length_in;
   logic [7:0]       space_count_ff, space_count_in;
   logic             line_begun_ff, line_begun_in;

   // Result register.
   logic         rsp_valid_ff, rsp_valid_in;
   cmd_code_type rsp_code_ff;
   logic [7:0]   rsp_count_ff;
   logic [15:0]  rsp_first_ff;
   logic [15:0]  rsp_second_ff;

   logic          out_free;
   logic          is_cr;
   logic          proc_fire;
   logic          take_byte;
   logic          word_write;
   field_ctl_type ctl_one;
   field_ctl_type ctl_two;
   logic [15:0]   value_one;
   logic [15:0]   value_two;
   cmd_code_type  match_code;

   // The output register can take a new transaction when it is empty or being emptied.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign is_cr     = (in_byte_ff == CHAR_CR);
   assign proc_fire = in_valid_ff && (!is_cr || out_free);
   assign req_ready = !in_valid_ff || proc_fire;

   // A line feed at the start of a line is dropped without touching anything.
   assign take_byte = proc_fire && !is_cr && !(in_byte_ff == CHAR_LF && !line_begun_ff);

   assign word_write = take_byte && in_byte_ff != CHAR_SPACE && space_count_ff == 8'd0
                       && word_length_ff < LEN_W'(WORD_MAX);

   always_comb begin
      ctl_one.clear = proc_fire && is_cr;
      ctl_two.clear = proc_fire && is_cr;
      ctl_one.step  = take_byte && in_byte_ff != CHAR_SPACE && space_count_ff == FIELD_ONE;
      ctl_two.step  = take_byte && in_byte_ff != CHAR_SPACE && space_count_ff == FIELD_TWO;
   end

   // Next line state.
   always_comb begin
      word_length_in = word_length_ff;
      space_count_in = space_count_ff;
      line_begun_in  = line_begun_ff;
      if (proc_fire && is_cr) begin
         word_length_in = '0;
         space_count_in = '0;
         line_begun_in  = 1'b0;
      end else if (take_byte) begin
         line_begun_in = 1'b1;
         if (in_byte_ff == CHAR_SPACE) begin
            if (space_count_ff != SPACE_COUNT_MAX) begin
               space_count_in = space_count_ff + 8'd1;
            end
         end else if (space_count_ff == 8'd0 && word_length_ff <= LEN_W'(WORD_MAX)) begin
            word_length_in = word_length_ff + LEN_W'(1);
         end
      end
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (proc_fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (proc_fire && is_cr) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   ccl_field u_field_one (
      .clock   (clock),
      .reset   (reset),
      .ctl     (ctl_one),
      .rx_byte (in_byte_ff),
      .value   (value_one)
   );

   ccl_field u_field_two (
      .clock   (clock),
      .reset   (reset),
      .ctl     (ctl_two),
      .rx_byte (in_byte_ff),
      .value   (value_two)
   );

   ccl_match #(
      .WORD_MAX (WORD_MAX),
      .LEN_W    (LEN_W)
   ) u_match (
      .word_chars   (word_chars_ff),
      .word_length  (word_length_ff),
      .command_code (match_code)
   );

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         word_length_ff <= '0;
         space_count_ff <= '0;
         line_begun_ff  <= 1'b0;
      end else begin
         in_valid_ff    <= in_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         word_length_ff <= word_length_in;
         space_count_ff <= space_count_in;
         line_begun_ff  <= line_begun_in;
      end
   end

   // Payload registers. Word characters are only compared up to the recorded length,
   // so stale characters from an earlier line never reach a result.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_rx_byte;
      end
      if (word_write) begin
         word_chars_ff[word_length_ff[IDX_W-1:0]] <= in_byte_ff;
      end
      if (proc_fire && is_cr) begin
         rsp_code_ff   <= match_code;
         rsp_count_ff  <= space_count_ff;
         rsp_first_ff  <= value_one;
         rsp_second_ff <= value_two;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_command_code = rsp_code_ff;
   assign rsp_field_count  = rsp_count_ff;
   assign rsp_first_value  = rsp_first_ff;
   assign rsp_second_value = rsp_second_ff;

endmodule : console_command_line_parser_unit
`default_nettype wire

// ===== rtl/ccl_field.sv =====
// Value accumulator of one argument field, decimal or hex.
`default_nettype none
module ccl_field (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire ccl_pkg::field_ctl_type ctl,
   input  wire logic [7:0]             rx_byte,
   output logic [15:0]                 value
);
   import ccl_pkg::*;

   logic [15:0] value_ff, value_in;
   logic        hex_ff, hex_in;
   logic [7:0]  digit_byte;
   logic [7:0]  nibble_byte;
   logic [15:0] times_sixteen;
   logic [15:0] times_ten;

   assign digit_byte    = rx_byte - CHAR_ZERO;
   assign nibble_byte   = rx_byte - CHAR_HEX_BASE;
   assign times_sixteen = {value_ff[11:0], 4'b0000};
   assign times_ten     = {value_ff[12:0], 3'b000} + {value_ff[14:0], 1'b0};

   always_comb begin
      value_in = value_ff;
      hex_in   = hex_ff;
      if (ctl.clear) begin
         value_in = '0;
         hex_in   = 1'b0;
      end else if (ctl.step) begin
         if (rx_byte >= CHAR_ZERO && rx_byte <= CHAR_NINE) begin
            if (hex_ff) begin
               value_in = times_sixteen + {8'h00, digit_byte};
            end else begin
               value_in = times_ten + {8'h00, digit_byte};
            end
         end else if (rx_byte == CHAR_HEX_MARK) begin
            value_in = '0;
            hex_in   = 1'b1;
         end else if (rx_byte >= CHAR_LOWER_A && rx_byte <= CHAR_LOWER_F) begin
            value_in = times_sixteen + {8'h00, nibble_byte};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         value_ff <= '0;
         hex_ff   <= 1'b0;
      end else begin
         value_ff <= value_in;
         hex_ff   <= hex_in;
      end
   end

   assign value = value_ff;

endmodule : ccl_field
`default_nettype wire

// ===== rtl/ccl_match.sv =====
// Comparison of the stored command word against the known command words.
`default_nettype none
module ccl_match #(
   parameter int WORD_MAX = ccl_pkg::WORD_MAX_DEFAULT,
   parameter int LEN_W    = $clog2(WORD_MAX + 2)
) (
   input  wire logic [7:0]           word_chars [WORD_MAX],
   input  wire logic [LEN_W-1:0]     word_length,
   output ccl_pkg::cmd_code_type     command_code
);
   import ccl_pkg::*;

   logic [KNOWN_WORDS-1:0] hit;

   // Every known word is checked at once; only its own length is compared.
   always_comb begin
      for (int k = 0; k < KNOWN_WORDS; k++) begin
         hit[k] = (word_length == LEN_W'(KNOWN_LEN[k]));
         for (int j = 0; j < KNOWN_MAX; j++) begin
            if (j < KNOWN_LEN[k] && word_chars[j] != KNOWN_TEXT[k][j]) begin
               hit[k] = 1'b0;
            end
         end
      end
   end

   always_comb begin
      command_code = CMD_UNKNOWN;
      if (hit[0]) begin
         command_code = CMD_FW;
      end else if (hit[1]) begin
         command_code = CMD_SOC;
      end else if (hit[2]) begin
         command_code = CMD_PHSOC;
      end else if (hit[3]) begin
         command_code = CMD_USB;
      end else if (hit[4]) begin
         command_code = CMD_WR;
      end else if (hit[5]) begin
         command_code = CMD_RD;
      end
   end

endmodule : ccl_match
`default_nettype wire

// ===== verif/console_command_line_parser_unit_tb.sv =====
// Self-checking testbench of the console command line parser unit.
`default_nettype none
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import ccl_pkg::*;

   // The unit keeps this many command word characters (its default parameter).
   localparam int KEEP = WORD_MAX_DEFAULT;

   // The run stops stimulus once this many bytes have had an effect on the line.
   localparam int BYTE_TARGET = 1400;

   // Watchdog limit, set far above the slowest correct run: about 1500 bytes, each sent after
   // a random idle gap, plus the waits of carriage returns on stalled results. So this limit
   // leaves a wide margin.
   localparam int CYCLE_LIMIT = 200000;

   // Cycles to wait after the last result. The checker stays active meanwhile, so any stray
   // result that follows still shows up as a mismatch.
   localparam int DRAIN_CYCLES = 8;

   // One line summary as the unit reports it.
   typedef struct packed {
      cmd_code_type code;
      logic [7:0]   count;
      logic [15:0]  first;
      logic [15:0]  second;
   } line_result_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [7:0]          req_rx_byte = 8'h00;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   cmd_code_type        rsp_command_code;
   logic [7:0]          rsp_field_count;
   logic [15:0]         rsp_first_value;
   logic [15:0]         rsp_second_value;

   // Line state of the predictor.
   logic [7:0]          kept_chars [KEEP];
   logic [3:0]          kept_len;
   logic [7:0]          field_index;
   logic [15:0]         arg_one;
   logic [15:0]         arg_two;
   logic                arg_one_hex;
   logic                arg_two_hex;
   logic                line_started;

   // Summaries predicted for lines whose carriage return has been accepted, oldest first.
   line_result_type     expected_lines [$];

   // Bytes of the next line to send.
   logic [7:0]          line_bytes [$];

   int                  bytes_sent = 0;
   int                  results_seen = 0;
   int                  mismatches = 0;
   int                  cycle_count = 0;

   // When set, neither side inserts idle cycles.
   bit                  steady = 1'b0;

   console_command_line_parser_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_command_code (rsp_command_code),
      .rsp_field_count  (rsp_field_count),
      .rsp_first_value  (rsp_first_value),
      .rsp_second_value (rsp_second_value)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Watchdog: a hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------------------------------

   // Spelling of each known command word.
   function automatic string command_word(input cmd_code_type code);
      case (code)
         CMD_FW:    return "pbfw";
         CMD_SOC:   return "pbsoc";
         CMD_PHSOC: return "pbphsoc";
         CMD_USB:   return "pbusb";
         CMD_WR:    return "pbwr";
         CMD_RD:    return "pbrd";
         default:   return "";
      endcase
   endfunction

   function automatic void clear_line();
      foreach (kept_chars[i]) kept_chars[i] = 8'h00;
      kept_len     = '0;
      field_index  = '0;
      arg_one      = '0;
      arg_two      = '0;
      arg_one_hex  = 1'b0;
      arg_two_hex  = 1'b0;
      line_started = 1'b0;
   endfunction

   // A word matches only if its full length equals the known word; a word longer than
   // KEEP has a length of KEEP+1 and so never matches.
   function automatic cmd_code_type match_word();
      string word;
      logic  same;
      for (int k = CMD_FW; k <= CMD_RD; k++) begin
         word = command_word(cmd_code_type'(k));
         same = (kept_len == word.len());
         for (int i = 0; i < word.len(); i++)
            if (kept_chars[i] != word[i]) same = 1'b0;
         if (same) return cmd_code_type'(k);
      end
      return CMD_UNKNOWN;
   endfunction

   // Next value of an argument field. Digits go in by ten, or by sixteen in hex mode;
   // the hex mark clears the value and selects hex mode; a-f always go in by sixteen.
   function automatic logic [15:0] next_arg(input logic [15:0] value, inout logic hex,
                                            input logic [7:0] c);
      logic [31:0] wide;
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         if (hex) wide = {12'd0, value, 4'h0} + (c - CHAR_ZERO);
         else     wide = {16'd0, value} * 32'd10 + (c - CHAR_ZERO);
         return wide[15:0];
      end
      if (c == CHAR_HEX_MARK) begin
         hex = 1'b1;
         return 16'h0000;
      end
      if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F) begin
         wide = {12'd0, value, 4'h0} + (c - CHAR_HEX_BASE);
         return wide[15:0];
      end
      return value;
   endfunction

   // Applies one accepted byte to the predicted line state. A carriage return queues the
   // summary of the line and starts a new one.
   function automatic void parse_byte(input logic [7:0] c);
      line_result_type summary;
      if (c == CHAR_CR) begin
         summary.code   = match_word();
         summary.count  = field_index;
         summary.first  = arg_one;
         summary.second = arg_two;
         expected_lines.push_back(summary);
         clear_line();
         bytes_sent++;
         return;
      end
      // A line feed before anything else on the line is dropped.
      if (c == CHAR_LF && !line_started) return;
      line_started = 1'b1;
      bytes_sent++;
      if (c == CHAR_SPACE) begin
         if (field_index != SPACE_COUNT_MAX) field_index++;
      end else if (field_index == 8'd0) begin
         if (kept_len < KEEP) kept_chars[kept_len] = c;
         if (kept_len <= KEEP) kept_len++;
      end else if (field_index == FIELD_ONE) begin
         arg_one = next_arg(arg_one, arg_one_hex, c);
      end else if (field_index == FIELD_TWO) begin
         arg_two = next_arg(arg_two, arg_two_hex, c);
      end
   endfunction

   // ---------------------------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------------------------

   function automatic int draw_gap();
      return steady ? 0 : int'($urandom_range(0, 5));
   endfunction

   // Sends one byte. The task is entered at a rising edge and returns at the edge where
   // the transaction is accepted, leaving req_valid high. The next call either lowers it
   // for its idle cycles or keeps it high, so req_valid is assigned once per time step.
   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = draw_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (req_ready !== 1'b1);
      parse_byte(b);
   endtask

   task automatic send_queued();
      foreach (line_bytes[i]) send_byte(line_bytes[i]);
      line_bytes.delete();
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) line_bytes.push_back(s[i]);
   endtask

   // Sends text followed by a carriage return.
   task automatic send_line(input string s);
      push_text(s);
      line_bytes.push_back(CHAR_CR);
      send_queued();
   endtask

   // ---------------------------------------------------------------------------------------
   // Result side: each result is compared, field by field, with the oldest prediction.
   // ---------------------------------------------------------------------------------------

   task automatic note_mismatch(input string what, input logic [15:0] want,
                                input logic [15:0] got);
      mismatches++;
      if (mismatches <= 10)
         $display("mismatch in result %0d, %s: expected %0h, got %0h",
                  results_seen, what, want, got);
   endtask

   initial begin : result_checker
      int              stall;
      line_result_type want;
      forever begin
         // The stall is drawn per result; with no stall rsp_ready simply stays high.
         stall = draw_gap();
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         results_seen++;
         if (expected_lines.size() == 0) begin
            note_mismatch("no result was expected", 16'h0000, 16'(rsp_command_code));
         end else begin
            want = expected_lines.pop_front();
            if (rsp_command_code !== want.code)
               note_mismatch("command code", 16'(want.code), 16'(rsp_command_code));
            if (rsp_field_count !== want.count)
               note_mismatch("field count", 16'(want.count), 16'(rsp_field_count));
            if (rsp_first_value !== want.first)
               note_mismatch("first value", want.first, rsp_first_value);
            if (rsp_second_value !== want.second)
               note_mismatch("second value", want.second, rsp_second_value);
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------------------

   // Empty line, line feeds at line start, a word cut short by a leading space, and a line
   // feed inside a word, where it is an ordinary character.
   task automatic test_empty_lines();
      send_line("");
      line_bytes.push_back(CHAR_LF);
      line_bytes.push_back(CHAR_LF);
      send_line("");
      send_line(" pbfw 3");
      push_text("pbrd");
      line_bytes.push_back(CHAR_LF);
      send_line("");
   endtask

   // Every known command, with none, one, two and three arguments.
   task automatic test_known_commands();
      send_line("pbfw");
      send_line("pbsoc 7");
      send_line("pbphsoc 12 x1f");
      send_line("pbusb xab cd");
      send_line("pbwr 65535 0");
      send_line("pbrd 9 8 7");
   endtask

   // Words of the largest kept length and beyond, prefixes, and the byte extremes.
   task automatic test_word_edges();
      send_line("pbphsocx");
      send_line("pbphsocxy");
      send_line("pbf");
      line_bytes.push_back(8'h00);
      line_bytes.push_back(8'hFF);
      send_line(" 1 2");
   endtask

   // Hex mark in mid field, wrap at 16 bits, and characters that fields ignore.
   task automatic test_field_edges();
      send_line("pbrd 12x34 5x");
      send_line("pbwr 65536 xfffff");
      send_line("pbsoc 1A2-3 Zz9");
   endtask

   // More than 255 spaces: the count saturates and the late bytes change nothing.
   task automatic test_space_saturation();
      push_text("pbwr 12 34");
      repeat (260) line_bytes.push_back(CHAR_SPACE);
      send_line("5");
   endtask

   function automatic logic [7:0] hex_char();
      int d;
      d = $urandom_range(0, 15);
      return (d < 10) ? CHAR_ZERO + 8'(d) : CHAR_LOWER_A + 8'(d - 10);
   endfunction

   function automatic logic [7:0] decimal_char();
      return CHAR_ZERO + 8'($urandom_range(0, 9));
   endfunction

   // Command word: mostly known words, else near misses and arbitrary bytes.
   task automatic add_word();
      int           pick;
      int           spot;
      string        word;
      logic [7:0]   c;
      pick = $urandom_range(0, 9);
      word = command_word(cmd_code_type'($urandom_range(CMD_FW, CMD_RD)));
      if (pick < 6) begin
         push_text(word);
      end else if (pick == 6) begin
         // One character replaced by a random lower-case letter.
         spot = $urandom_range(0, word.len() - 1);
         for (int i = 0; i < word.len(); i++)
            line_bytes.push_back((i == spot) ? 8'($urandom_range(8'h61, 8'h7A)) : word[i]);
      end else if (pick == 7) begin
         // Prefix of a known word, or the word with something appended.
         if ($urandom_range(0, 1)) push_text(word.substr(0, $urandom_range(0, word.len() - 2)));
         else push_text({word, word.substr(0, $urandom_range(0, word.len() - 1))});
      end else begin
         repeat ($urandom_range(1, 11)) begin
            c = 8'($urandom_range(0, 255));
            if (c != CHAR_SPACE && c != CHAR_CR) line_bytes.push_back(c);
         end
      end
   endtask

   // Content of one argument field.
   task automatic add_field();
      int n;
      n = $urandom_range(1, 6);
      case ($urandom_range(0, 9))
         0, 1, 2, 3: repeat (n) line_bytes.push_back(decimal_char());
         4, 5, 6: begin
            line_bytes.push_back(CHAR_HEX_MARK);
            repeat (n) line_bytes.push_back(hex_char());
         end
         7: repeat (n) line_bytes.push_back(hex_char());
         8: repeat (n) line_bytes.push_back(8'($urandom_range(8'h21, 8'h7E)));
         default: begin
            repeat (n) line_bytes.push_back(decimal_char());
            line_bytes.push_back(CHAR_HEX_MARK);
            repeat ($urandom_range(0, 5)) line_bytes.push_back(hex_char());
         end
      endcase
   endtask

   // Most lines are well formed with random content; the rest are raw noise.
   task automatic build_random_line();
      if ($urandom_range(0, 7) == 0) line_bytes.push_back(CHAR_LF);
      if ($urandom_range(0, 99) < 82) begin
         add_word();
         repeat ($urandom_range(0, 4)) begin
            line_bytes.push_back(CHAR_SPACE);
            if ($urandom_range(0, 7) == 0) line_bytes.push_back(CHAR_SPACE);
            add_field();
         end
         if ($urandom_range(0, 7) == 0) line_bytes.push_back(CHAR_SPACE);
      end else begin
         // Any byte at all, including embedded carriage returns and line feeds.
         repeat ($urandom_range(0, 15)) line_bytes.push_back(8'($urandom_range(0, 255)));
      end
      line_bytes.push_back(CHAR_CR);
   endtask

   task automatic test_random_lines();
      while (bytes_sent < BYTE_TARGET) begin
         // Now and then switch between idling and back-to-back stretches.
         if ($urandom_range(0, 11) == 0) steady = !steady;
         build_random_line();
         send_queued();
      end
      steady = 1'b0;
   endtask

   // ---------------------------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------------------------

   initial begin
      clear_line();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_empty_lines();
      test_known_commands();
      test_word_edges();
      test_field_edges();
      test_space_saturation();
      test_random_lines();

      // Let the last transaction go, then wait for every predicted line summary.
      req_valid <= 1'b0;
      while (expected_lines.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0 && expected_lines.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
`default_nettype wire
